// ===== hw/rtl/mf3_pkg.sv =====
`timescale 1ns / 1ps
// mf3_pkg: shared types, codes and compare helpers for the 3x3 median filter.
// No dependencies; imported by mf3_ctrl, mf3_median and the top level.
package mf3_pkg;

    localparam int SAMPLE_W  = 16;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = 16;
    localparam int CH_CFG_W  = 3;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_COUNT = 2'd2;

    // Input beat kinds
    localparam logic ACT_SAMPLE = 1'b0;
    localparam logic ACT_DRAIN  = 1'b1;

    // Per-beat command handed from the control stage to the datapath
    typedef struct packed {
        logic wr;          // sample beat: update row stores and window
        logic produced;    // beat yields a result
        logic interior;    // result is the 3x3 median
        logic use_edge;    // result is the last-column sample two rows back
        logic drain;       // result comes from a row store read
        logic drain_upper; // drain reads the upper row store
        logic last;        // final result of the frame
    } cmd_t;

    function automatic logic [SAMPLE_W-1:0] min2(input logic [SAMPLE_W-1:0] a,
                                                 input logic [SAMPLE_W-1:0] b);
        return (a < b) ? a : b;
    endfunction

    function automatic logic [SAMPLE_W-1:0] max2(input logic [SAMPLE_W-1:0] a,
                                                 input logic [SAMPLE_W-1:0] b);
        return (a < b) ? b : a;
    endfunction

    function automatic logic [SAMPLE_W-1:0] min3(input logic [SAMPLE_W-1:0] a,
                                                 input logic [SAMPLE_W-1:0] b,
                                                 input logic [SAMPLE_W-1:0] c);
        return min2(min2(a, b), c);
    endfunction

    function automatic logic [SAMPLE_W-1:0] max3(input logic [SAMPLE_W-1:0] a,
                                                 input logic [SAMPLE_W-1:0] b,
                                                 input logic [SAMPLE_W-1:0] c);
        return max2(max2(a, b), c);
    endfunction

    function automatic logic [SAMPLE_W-1:0] med3(input logic [SAMPLE_W-1:0] a,
                                                 input logic [SAMPLE_W-1:0] b,
                                                 input logic [SAMPLE_W-1:0] c);
        return max2(min2(a, b), min2(max2(a, b), c));
    endfunction

endpackage

// ===== hw/rtl/mf3_ram.sv =====
`timescale 1ns / 1ps
// mf3_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
module mf3_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 8192,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== hw/rtl/mf3_ctrl.sv =====
`timescale 1ns / 1ps
// mf3_ctrl: configuration registers, frame position, drain count and store addressing.
// Depends on mf3_pkg.
module mf3_ctrl #(
    parameter int MAX_WIDTH    = 2048,
    parameter int MAX_CHANNELS = 4,
    parameter int SAMPLE_BITS  = 16,
    localparam int AW  = $clog2(MAX_WIDTH * MAX_CHANNELS),
    localparam int CB  = $clog2(MAX_WIDTH),
    localparam int CHB = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           en,
    input  logic                           in_valid,
    input  logic                           in_action,
    input  logic [mf3_pkg::SAMPLE_W-1:0]   in_sample,
    input  logic                           cfg_we,
    input  logic [mf3_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [mf3_pkg::CFG_W-1:0]      cfg_data,
    output logic [AW-1:0]                  rd_addr_a,
    output logic [AW-1:0]                  rd_addr_b,
    output mf3_pkg::cmd_t                  p1_cmd,
    output logic [CHB-1:0]                 p1_ch,
    output logic [AW-1:0]                  p1_idx,
    output logic [SAMPLE_BITS-1:0]         p1_sample,
    output logic                           pend_zero
);

    import mf3_pkg::*;

    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int PW = $clog2((MAX_WIDTH + 1) * MAX_CHANNELS + 1);

    logic [11:0]         cfg_w_reg;
    logic [15:0]         cfg_h_reg;
    logic [CH_CFG_W-1:0] cfg_c_reg;

    logic [CB-1:0]  col_reg, col_next;
    logic [15:0]    row_reg, row_next;
    logic [CHB-1:0] ch_reg, ch_next;
    logic [PW-1:0]  pend_reg, pend_next;

    cmd_t           cmd_reg, cmd_next;
    logic [CHB-1:0] p1_ch_reg;
    logic [AW-1:0]  p1_idx_reg;
    logic [SAMPLE_BITS-1:0] p1_sample_reg;

    logic [WW-1:0]       w_eff;
    logic [CH_CFG_W-1:0] c_eff;
    logic [15:0]         h_eff;
    logic [PW-1:0]       w_p, c_p, wc, lagc, wm1c_p, frame_pend, d, dch, mid_addr_p;
    logic [AW-1:0]       wm1c, idx, edge_addr, drain_addr;
    logic                acc, restart;
    logic [CB-1:0]       col0;
    logic [15:0]         row0;
    logic [CHB-1:0]      ch0;
    logic [CH_CFG_W-1:0] ch_inc;
    logic [WW-1:0]       col_inc;
    logic [16:0]         row_inc;
    logic                interior, produced;

    // Effective geometry: zero acts as one, oversize clamps to the maximum
    always_comb begin
        if (cfg_w_reg == '0) begin
            w_eff = WW'(1);
        end else if (32'(cfg_w_reg) > 32'(MAX_WIDTH)) begin
            w_eff = WW'(MAX_WIDTH);
        end else begin
            w_eff = WW'(cfg_w_reg);
        end
        if (cfg_c_reg == '0) begin
            c_eff = CH_CFG_W'(1);
        end else if (32'(cfg_c_reg) > 32'(MAX_CHANNELS)) begin
            c_eff = CH_CFG_W'(MAX_CHANNELS);
        end else begin
            c_eff = cfg_c_reg;
        end
        h_eff = (cfg_h_reg == '0) ? 16'd1 : cfg_h_reg;
    end

    assign w_p        = PW'(w_eff);
    assign c_p        = PW'(c_eff);
    assign wc         = w_p * c_p;
    assign lagc       = (w_p + PW'(1)) * c_p;
    assign wm1c_p     = (w_p - PW'(1)) * c_p;
    assign wm1c       = wm1c_p[AW-1:0];
    // A one-row frame drains all of itself, taller ones a row plus a pixel
    assign frame_pend = (h_eff == 16'd1) ? wc : lagc;

    assign acc     = in_valid && en;
    assign restart = (row_reg >= h_eff);
    assign row0    = restart ? '0 : row_reg;
    assign col0    = restart ? '0 : col_reg;
    assign ch0     = restart ? '0 : ch_reg;

    assign idx       = AW'(col0) * AW'(c_eff) + AW'(ch0);
    assign edge_addr = wm1c + ((CH_CFG_W'(ch0) < c_eff) ? AW'(ch0) : '0);

    // Drain addressing: the last pixel of the upper row first, then the middle row
    assign d          = pend_reg - wc;
    assign dch        = (d <= c_p) ? (c_p - d) : '0;
    assign mid_addr_p = wc - pend_reg;
    assign drain_addr = (pend_reg > wc) ? (wm1c + AW'(dch)) : mid_addr_p[AW-1:0];

    assign rd_addr_a = (in_action == ACT_DRAIN) ? drain_addr : idx;
    assign rd_addr_b = edge_addr;

    assign interior = (row0 >= 16'd2) && (({1'b0, row0} + 17'd1) <= {1'b0, h_eff})
                   && (col0 >= CB'(2)) && ((WW'(col0) + WW'(1)) <= w_eff);
    assign produced = (col0 != '0) ? (row0 >= 16'd1) : (row0 >= 16'd2);

    assign ch_inc  = CH_CFG_W'(ch0) + CH_CFG_W'(1);
    assign col_inc = WW'(col0) + WW'(1);
    assign row_inc = {1'b0, row0} + 17'd1;

    always_comb begin
        col_next  = col_reg;
        row_next  = row_reg;
        ch_next   = ch_reg;
        pend_next = pend_reg;
        cmd_next  = '0;
        if (acc) begin
            if (in_action == ACT_DRAIN) begin
                if (pend_reg != '0) begin
                    pend_next            = pend_reg - PW'(1);
                    cmd_next.produced    = 1'b1;
                    cmd_next.drain       = 1'b1;
                    cmd_next.drain_upper = (pend_reg > wc);
                    cmd_next.last        = (pend_reg == PW'(1));
                    if (pend_reg == PW'(1)) begin
                        col_next = '0;
                        row_next = '0;
                        ch_next  = '0;
                    end
                end
            end else if (pend_reg == '0) begin
                cmd_next.wr       = 1'b1;
                cmd_next.produced = produced;
                cmd_next.interior = interior;
                cmd_next.use_edge = (col0 == '0);
                ch_next  = ch0;
                col_next = col0;
                row_next = row0;
                if (ch_inc >= c_eff) begin
                    ch_next = '0;
                    if (col_inc >= w_eff) begin
                        col_next = '0;
                        row_next = row_inc[15:0];
                        if (row_inc[15:0] >= h_eff) begin
                            pend_next = frame_pend;
                        end
                    end else begin
                        col_next = col_inc[CB-1:0];
                    end
                end else begin
                    ch_next = ch_inc[CHB-1:0];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_w_reg <= 12'd2048;
            cfg_h_reg <= 16'd1080;
            cfg_c_reg <= CH_CFG_W'(3);
            col_reg   <= '0;
            row_reg   <= '0;
            ch_reg    <= '0;
            pend_reg  <= '0;
            cmd_reg   <= '0;
        end else begin
            if (cfg_we) begin
                unique case (cfg_index)
                    CFG_IMAGE_WIDTH:   cfg_w_reg <= cfg_data[11:0];
                    CFG_IMAGE_HEIGHT:  cfg_h_reg <= cfg_data;
                    CFG_CHANNEL_COUNT: cfg_c_reg <= cfg_data[CH_CFG_W-1:0];
                    default:           ;
                endcase
            end
            col_reg  <= col_next;
            row_reg  <= row_next;
            ch_reg   <= ch_next;
            pend_reg <= pend_next;
            if (en) begin
                cmd_reg <= cmd_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            p1_ch_reg     <= ch0;
            p1_idx_reg    <= idx;
            p1_sample_reg <= in_sample[SAMPLE_BITS-1:0];
        end
    end

    assign p1_cmd    = cmd_reg;
    assign p1_ch     = p1_ch_reg;
    assign p1_idx    = p1_idx_reg;
    assign p1_sample = p1_sample_reg;
    assign pend_zero = (pend_reg == '0);

endmodule

// ===== hw/rtl/mf3_median.sv =====
`timescale 1ns / 1ps
// mf3_median: two-stage 3x3 median network followed by the result register.
// Depends on mf3_pkg.
module mf3_median (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                en,
    input  logic                                in_valid,
    input  logic                                in_last,
    input  logic                                in_bypass,
    input  logic [mf3_pkg::SAMPLE_W-1:0]        in_byp_val,
    input  logic [8:0][mf3_pkg::SAMPLE_W-1:0]   in_win,
    output logic                                out_valid,
    output logic                                out_last,
    output logic [mf3_pkg::SAMPLE_W-1:0]        out_sample
);

    import mf3_pkg::*;

    logic                      a_valid_reg, a_last_reg, a_byp_reg;
    logic [SAMPLE_W-1:0]       a_byp_val_reg;
    logic [2:0][SAMPLE_W-1:0]  a_lo_reg, a_md_reg, a_hi_reg;
    logic                      o_valid_reg, o_last_reg;
    logic [SAMPLE_W-1:0]       o_sample_reg, o_sample_next;

    // Stage A: sort each row of three
    always_ff @(posedge aclk) begin
        if (en) begin
            a_byp_val_reg <= in_byp_val;
            a_last_reg    <= in_last;
            a_byp_reg     <= in_bypass;
            for (int r = 0; r < 3; r++) begin
                a_lo_reg[r] <= min3(in_win[r*3], in_win[r*3+1], in_win[r*3+2]);
                a_md_reg[r] <= med3(in_win[r*3], in_win[r*3+1], in_win[r*3+2]);
                a_hi_reg[r] <= max3(in_win[r*3], in_win[r*3+1], in_win[r*3+2]);
            end
        end
    end

    // Stage B: bypass value, or max of minima, median of medians, min of maxima, then median
    always_comb begin
        if (a_byp_reg) begin
            o_sample_next = a_byp_val_reg;
        end else begin
            o_sample_next = med3(max3(a_lo_reg[0], a_lo_reg[1], a_lo_reg[2]),
                                 med3(a_md_reg[0], a_md_reg[1], a_md_reg[2]),
                                 min3(a_hi_reg[0], a_hi_reg[1], a_hi_reg[2]));
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            o_sample_reg <= o_sample_next;
            o_last_reg   <= a_last_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            o_valid_reg <= 1'b0;
        end else if (en) begin
            a_valid_reg <= in_valid;
            o_valid_reg <= a_valid_reg;
        end
    end

    assign out_valid  = o_valid_reg;
    assign out_last   = o_last_reg && o_valid_reg;
    assign out_sample = o_sample_reg;

endmodule

// ===== hw/rtl/median_filter_3x3_unit.sv =====
`timescale 1ns / 1ps
// median_filter_3x3_unit: top level of the streaming 3x3 median filter.
// Depends on mf3_pkg, mf3_ram, mf3_ctrl and mf3_median.

// Streams channel-interleaved samples in raster order and returns, one row plus
// one pixel later, the median of each interior sample's 3x3 same-channel
// neighbourhood; border samples are copied. Drain beats (action = 1) release the
// held-back outputs once the frame is complete, the last carrying m_frame_last.
// One beat is taken every clock while the result side keeps up; a result leaves
// through the control stage, the row store read and window update, and the two
// median network stages. All stages advance together and halt only while the
// result register holds an untaken beat. The row stores are three single-read
// RAMs of MAX_WIDTH x MAX_CHANNELS entries; they need no clearing pass after
// reset, as a result never depends on an unwritten entry.
// Write configuration only while the block is idle.
module median_filter_3x3_unit #(
    parameter int MAX_WIDTH    = 2048,
    parameter int MAX_CHANNELS = 4,
    parameter int SAMPLE_BITS  = 16
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic                          s_action,
    input  logic [mf3_pkg::SAMPLE_W-1:0]  s_sample_value,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [mf3_pkg::SAMPLE_W-1:0]  m_out_sample,
    output logic                          m_frame_last,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [mf3_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [mf3_pkg::CFG_W-1:0]     cfg_data
);

    import mf3_pkg::*;

    localparam int DEPTH = MAX_WIDTH * MAX_CHANNELS;
    localparam int AW    = $clog2(DEPTH);
    localparam int CHB   = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int SB    = SAMPLE_BITS;

    logic           en;
    logic [AW-1:0]  rd_addr_a, rd_addr_b, p1_idx;
    cmd_t           p1_cmd;
    logic [CHB-1:0] p1_ch;
    logic [SB-1:0]  p1_sample;
    logic           pend_zero;

    logic [SB-1:0]  up_a_q, up_b_q, mid_q;
    logic [SB-1:0]  up_eff, mid_eff, edge_eff;
    logic           s1_we;

    // Bypass of a store write that lands on the edge where a read is issued
    logic           fwd_a_reg, fwd_b_reg;
    logic [SB-1:0]  fwd_up_a_reg, fwd_mid_reg, fwd_up_b_reg;

    // Window lanes: per channel, the two newest columns of three rows
    logic [SB-1:0]  win_reg [MAX_CHANNELS][6];
    logic [8:0][SB-1:0] win_new;

    logic           p2_valid_reg, p2_last_reg, p2_byp_reg;
    logic [SB-1:0]  p2_byp_val_reg, byp_val;
    logic [8:0][SB-1:0] p2_win_reg;
    logic [8:0][SAMPLE_W-1:0] p2_win_ext;

    // Every stage advances whenever the result register is free or being taken
    assign en        = !m_valid || m_ready;
    assign s_ready   = en;
    assign cfg_ready = 1'b1;

    mf3_ctrl #(
        .MAX_WIDTH    (MAX_WIDTH),
        .MAX_CHANNELS (MAX_CHANNELS),
        .SAMPLE_BITS  (SAMPLE_BITS)
    ) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (s_valid),
        .in_action (s_action),
        .in_sample (s_sample_value),
        .cfg_we    (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .rd_addr_a (rd_addr_a),
        .rd_addr_b (rd_addr_b),
        .p1_cmd    (p1_cmd),
        .p1_ch     (p1_ch),
        .p1_idx    (p1_idx),
        .p1_sample (p1_sample),
        .pend_zero (pend_zero)
    );

    // Write the shifted rows back on the beat's next advance after the read
    assign s1_we = en && p1_cmd.wr;

    // Two copies of the upper store: one for the window column, one for the edge
    mf3_ram #(.WIDTH(SB), .DEPTH(DEPTH)) u_upper_a (
        .aclk  (aclk),
        .we    (s1_we),
        .waddr (p1_idx),
        .wdata (mid_eff),
        .re    (en),
        .raddr (rd_addr_a),
        .rdata (up_a_q)
    );

    mf3_ram #(.WIDTH(SB), .DEPTH(DEPTH)) u_upper_b (
        .aclk  (aclk),
        .we    (s1_we),
        .waddr (p1_idx),
        .wdata (mid_eff),
        .re    (en),
        .raddr (rd_addr_b),
        .rdata (up_b_q)
    );

    mf3_ram #(.WIDTH(SB), .DEPTH(DEPTH)) u_middle (
        .aclk  (aclk),
        .we    (s1_we),
        .waddr (p1_idx),
        .wdata (p1_sample),
        .re    (en),
        .raddr (rd_addr_a),
        .rdata (mid_q)
    );

    // Capture bypass data when the beat ahead writes the address being read
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fwd_a_reg <= 1'b0;
            fwd_b_reg <= 1'b0;
        end else if (en) begin
            fwd_a_reg <= p1_cmd.wr && (rd_addr_a == p1_idx);
            fwd_b_reg <= p1_cmd.wr && (rd_addr_b == p1_idx);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            fwd_up_a_reg <= mid_eff;
            fwd_mid_reg  <= p1_sample;
            fwd_up_b_reg <= mid_eff;
        end
    end

    assign up_eff   = fwd_a_reg ? fwd_up_a_reg : up_a_q;
    assign mid_eff  = fwd_a_reg ? fwd_mid_reg  : mid_q;
    assign edge_eff = fwd_b_reg ? fwd_up_b_reg : up_b_q;

    // Shift the channel's window one column and append the new column
    always_comb begin
        for (int r = 0; r < 3; r++) begin
            win_new[r*3]   = win_reg[p1_ch][r*2];
            win_new[r*3+1] = win_reg[p1_ch][r*2+1];
        end
        win_new[2] = up_eff;
        win_new[5] = mid_eff;
        win_new[8] = p1_sample;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int c = 0; c < MAX_CHANNELS; c++) begin
                for (int k = 0; k < 6; k++) begin
                    win_reg[c][k] <= '0;
                end
            end
        end else if (s1_we) begin
            for (int r = 0; r < 3; r++) begin
                win_reg[p1_ch][r*2]   <= win_new[r*3+1];
                win_reg[p1_ch][r*2+1] <= win_new[r*3+2];
            end
        end
    end

    // Pick the copied value for border, edge and drain beats
    always_comb begin
        priority if (p1_cmd.drain) begin
            byp_val = p1_cmd.drain_upper ? up_eff : mid_eff;
        end else if (p1_cmd.use_edge) begin
            byp_val = edge_eff;
        end else begin
            byp_val = win_new[4];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p2_valid_reg <= 1'b0;
        end else if (en) begin
            p2_valid_reg <= p1_cmd.produced;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            p2_last_reg    <= p1_cmd.last;
            p2_byp_reg     <= !p1_cmd.interior;
            p2_byp_val_reg <= byp_val;
            p2_win_reg     <= win_new;
        end
    end

    always_comb begin
        for (int i = 0; i < 9; i++) begin
            p2_win_ext[i] = SAMPLE_W'(p2_win_reg[i]);
        end
    end

    mf3_median u_median (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .en         (en),
        .in_valid   (p2_valid_reg),
        .in_last    (p2_last_reg),
        .in_bypass  (p2_byp_reg),
        .in_byp_val (SAMPLE_W'(p2_byp_val_reg)),
        .in_win     (p2_win_ext),
        .out_valid  (m_valid),
        .out_last   (m_frame_last),
        .out_sample (m_out_sample)
    );

    // The frame-ending beat is always a drain result that writes nothing
    a_last_is_drain: assert property (@(posedge aclk) disable iff (!aresetn)
        p1_cmd.last |-> (p1_cmd.drain && p1_cmd.produced && !p1_cmd.wr))
        else $error("frame end marked on a non-drain beat");

    // A drain with nothing held back must vanish
    a_empty_drain: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && (s_action == ACT_DRAIN) && pend_zero) |=> !p1_cmd.produced)
        else $error("drain with nothing pending produced a result");

    // A sample beat taken while a finished frame still drains writes nothing
    a_no_write_while_draining: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && (s_action == ACT_SAMPLE) && !pend_zero) |=> !p1_cmd.wr)
        else $error("sample written into the stores during drain");

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// tb_top: self-checking testbench for median_filter_3x3_unit.
// Depends on mf3_pkg and the filter RTL; needs no files or arguments.

// The testbench drives frames of channel-interleaved samples followed by drain
// beats. A predictor inside the bench keeps its own row stores, window and
// position, and it works out the filtered sample for every accepted beat.
// A checker process compares each result beat with the oldest expected sample.
// Directed tests cover the extremes of the registers and the values, the
// corner cases of drain and frame, and the pass-through of tiny frames.
// A random part then runs several hundred beats of small frames under three
// idling mixes.
module tb_top;
    import mf3_pkg::*;

    localparam int STORE_DEPTH = 2048 * 4;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_GAP = 12;   // four-stage pipe plus margin

    typedef struct {
        logic [SAMPLE_W-1:0] sample;
        logic                last;
    } filtered_t;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_valid = 1'b0;
    logic                 s_ready;
    logic                 s_action = ACT_SAMPLE;
    logic [SAMPLE_W-1:0]  s_sample_value = '0;
    logic                 m_valid;
    logic                 m_ready = 1'b0;
    logic [SAMPLE_W-1:0]  m_out_sample;
    logic                 m_frame_last;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = CFG_IMAGE_WIDTH;
    logic [CFG_W-1:0]     cfg_data = '0;

    median_filter_3x3_unit DUT (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_action       (s_action),
        .s_sample_value (s_sample_value),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_out_sample   (m_out_sample),
        .m_frame_last   (m_frame_last),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    // Predictor state: mirrors the block's row stores, windows and position
    logic [SAMPLE_W-1:0] upper_rows [STORE_DEPTH];
    logic [SAMPLE_W-1:0] middle_rows [STORE_DEPTH];
    logic [SAMPLE_W-1:0] windows [36];
    int unsigned col_at, row_at, chan_at, pending;
    int unsigned reg_width, reg_height, reg_channels;

    filtered_t expected_q[$];
    int fail_count = 0;
    int result_count = 0;
    int beat_count = 0;
    int frame_count = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int stall_cycles = 0;

    initial begin
        forever #5 aclk = ~aclk;
    end

    // Median of the nine window registers of one channel, by insertion sort
    function automatic logic [SAMPLE_W-1:0] median_of_window(input int base);
        logic [SAMPLE_W-1:0] v [9];
        logic [SAMPLE_W-1:0] t;
        int j;
        for (int i = 0; i < 9; i++) v[i] = windows[base + i];
        for (int i = 1; i < 9; i++) begin
            t = v[i];
            j = i;
            while (j > 0 && v[j - 1] > t) begin
                v[j] = v[j - 1];
                j--;
            end
            v[j] = t;
        end
        return v[4];
    endfunction

    // Advance the predictor by one accepted beat; returns 1 when it yields a result
    function automatic bit filter_beat(input logic act, input logic [SAMPLE_W-1:0] s,
                                       output filtered_t res);
        int unsigned w, h, c, wc, d, ch, idx, base, c0, r0;
        longint unsigned total, lag;
        logic [SAMPLE_W-1:0] up, mid, edge_v;
        bit produced;
        w = (reg_width == 0) ? 1 : ((reg_width > 2048) ? 2048 : reg_width);
        h = (reg_height == 0) ? 1 : reg_height;
        c = (reg_channels == 0) ? 1 : ((reg_channels > 4) ? 4 : reg_channels);
        wc = w * c;
        res.sample = '0;
        res.last = 1'b0;
        produced = 1'b0;
        if (act == ACT_DRAIN) begin
            if (pending == 0) return 1'b0;
            if (pending > wc) begin
                d = pending - wc;
                ch = (d <= c) ? c - d : 0;
                res.sample = upper_rows[(w - 1) * c + ch];
            end else begin
                res.sample = middle_rows[wc - pending];
            end
            pending--;
            res.last = (pending == 0);
            if (pending == 0) begin
                col_at = 0;
                row_at = 0;
                chan_at = 0;
            end
            return 1'b1;
        end
        if (pending != 0) return 1'b0;
        if (row_at >= h) begin
            col_at = 0;
            row_at = 0;
            chan_at = 0;
        end
        c0 = col_at;
        r0 = row_at;
        ch = chan_at;
        idx = c0 * c + ch;
        edge_v = upper_rows[(w - 1) * c + ((ch < c) ? ch : 0)];
        if (idx >= STORE_DEPTH) idx = STORE_DEPTH - 1;
        up = upper_rows[idx];
        mid = middle_rows[idx];
        upper_rows[idx] = mid;
        middle_rows[idx] = s;
        base = ch * 9;
        for (int r = 0; r < 3; r++) begin
            windows[base + r * 3] = windows[base + r * 3 + 1];
            windows[base + r * 3 + 1] = windows[base + r * 3 + 2];
        end
        windows[base + 2] = up;
        windows[base + 5] = mid;
        windows[base + 8] = s;
        if (c0 >= 1) begin
            if (r0 >= 1) begin
                // interior means a full neighbourhood around (r0-1, c0-1)
                if (r0 >= 2 && r0 + 1 <= h && c0 >= 2 && c0 + 1 <= w)
                    res.sample = median_of_window(base);
                else
                    res.sample = windows[base + 4];
                produced = 1'b1;
            end
        end else if (r0 >= 2) begin
            // first column: release the last-column sample two rows back
            res.sample = edge_v;
            produced = 1'b1;
        end
        ch++;
        if (ch >= c) begin
            ch = 0;
            c0++;
            if (c0 >= w) begin
                c0 = 0;
                r0++;
            end
        end
        chan_at = ch;
        col_at = c0;
        row_at = r0;
        if (r0 >= h) begin
            total = longint'(wc) * h;
            lag = longint'(w + 1) * c;
            pending = 32'((total < lag) ? total : lag);
        end
        return produced;
    endfunction

    // Send one beat; valid stays up afterwards until the next call decides
    task automatic send_beat(input logic act, input logic [SAMPLE_W-1:0] value);
        filtered_t res;
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_action <= act;
        s_sample_value <= value;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        beat_count++;
        if (filter_beat(act, value, res)) expected_q.push_back(res);
    endtask

    // Wait for the pipe to empty, then write one register
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        s_valid <= 1'b0;
        while (expected_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_GAP) @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_IMAGE_WIDTH: begin
                reg_width = data & 16'h0FFF;
            end
            CFG_IMAGE_HEIGHT: begin
                reg_height = data;
            end
            CFG_CHANNEL_COUNT: begin
                reg_channels = data & 16'h0007;
            end
            default: begin
            end
        endcase
    endtask

    task automatic set_geometry(input int unsigned w, input int unsigned h,
                                input int unsigned c);
        write_reg(CFG_IMAGE_WIDTH, {4'($urandom), 12'(w)});
        write_reg(CFG_IMAGE_HEIGHT, 16'(h));
        write_reg(CFG_CHANNEL_COUNT, {13'($urandom), 3'(c)});
    endtask

    function automatic logic [SAMPLE_W-1:0] pick_value(input int flavour);
        case (flavour)
            0: return 16'($urandom_range(3));              // many ties
            1: return $urandom_range(1) ? 16'hFFFF : 16'h0000;
            default: return 16'($urandom);
        endcase
    endfunction

    // Push one full frame, sprinkle ignored beats, then drain it out
    task automatic run_frame(input int flavour, input int noise_pct);
        int unsigned w, h, c, n;
        w = (reg_width == 0) ? 1 : ((reg_width > 2048) ? 2048 : reg_width);
        h = (reg_height == 0) ? 1 : reg_height;
        c = (reg_channels == 0) ? 1 : ((reg_channels > 4) ? 4 : reg_channels);
        n = w * h * c;
        for (int unsigned i = 0; i < n; i++) begin
            // a drain mid-frame has nothing pending and is dropped
            if ($urandom_range(99) < noise_pct) send_beat(ACT_DRAIN, 16'($urandom));
            send_beat(ACT_SAMPLE, pick_value(flavour));
        end
        while (pending != 0) begin
            // samples past the frame end are dropped while outputs are held
            if ($urandom_range(99) < noise_pct) send_beat(ACT_SAMPLE, 16'($urandom));
            else send_beat(ACT_DRAIN, 16'($urandom));
        end
        frame_count++;
    endtask

    task automatic test_idle_drain;
        send_beat(ACT_DRAIN, 16'hFFFF);
        send_beat(ACT_DRAIN, 16'h0000);
    endtask

    task automatic test_tiny_frames;
        // zero width and height act as one: a single sample passes straight through
        set_geometry(0, 0, 1);
        run_frame(1, 0);
        set_geometry(2, 2, 2);
        run_frame(2, 0);
        // seven channels act as four
        set_geometry(1, 3, 7);
        run_frame(2, 0);
    endtask

    task automatic test_single_median;
        set_geometry(3, 3, 1);
        run_frame(1, 30);
        set_geometry(3, 3, 1);
        run_frame(2, 0);
    endtask

    task automatic test_register_extremes;
        // tallest frame is written but the height is cut back before any beat
        write_reg(CFG_IMAGE_HEIGHT, 16'hFFFF);
        set_geometry(4, 3, 4);
        run_frame(0, 0);
    endtask

    task automatic test_random_frames(input int beats);
        int stop_at;
        stop_at = beat_count + beats;
        while (beat_count < stop_at) begin
            set_geometry($urandom_range(9) == 0 ? 0 : $urandom_range(1, 7),
                         $urandom_range(9) == 0 ? 0 : $urandom_range(1, 5),
                         $urandom_range(9) == 0 ? $urandom_range(5, 7) : $urandom_range(1, 4));
            run_frame($urandom_range(2), $urandom_range(3) == 0 ? 15 : 0);
        end
    endtask

    // Result side: stall at random with the current mix
    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Compare every result beat with the oldest expected sample
    always @(posedge aclk) begin
        filtered_t exp_res;
        if (aresetn && m_valid && m_ready) begin
            result_count++;
            if (expected_q.size() == 0) begin
                $display("%0t: unexpected beat sample=%h last=%b", $time,
                         m_out_sample, m_frame_last);
                fail_count++;
            end else begin
                exp_res = expected_q.pop_front();
                if (m_out_sample !== exp_res.sample) begin
                    $display("%0t: out_sample expected %h actual %h", $time,
                             exp_res.sample, m_out_sample);
                    fail_count++;
                end
                if (m_frame_last !== exp_res.last) begin
                    $display("%0t: frame_last expected %b actual %b", $time,
                             exp_res.last, m_frame_last);
                    fail_count++;
                end
            end
        end
    end

    // Watchdog: count cycles with no beat moving on any channel
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)
            || !aresetn) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: watchdog expired, %0d samples outstanding", $time,
                     expected_q.size());
            $display("RESULT: ERROR");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        for (int i = 0; i < STORE_DEPTH; i++) begin
            upper_rows[i] = '0;
            middle_rows[i] = '0;
        end
        for (int i = 0; i < 36; i++) windows[i] = '0;
        col_at = 0;
        row_at = 0;
        chan_at = 0;
        pending = 0;
        reg_width = 2048;
        reg_height = 1080;
        reg_channels = 3;

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_idle_drain();
        test_tiny_frames();
        test_single_median();
        test_register_extremes();

        send_idle_pct = 34;
        recv_idle_pct = 46;
        test_random_frames(150);
        send_idle_pct = 46;
        recv_idle_pct = 34;
        test_random_frames(150);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_frames(150);

        s_valid <= 1'b0;
        while (expected_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_GAP) @(posedge aclk);

        $display("Covered %0d input beats over %0d frames, %0d result beats checked.",
                 beat_count, frame_count, result_count);
        if (fail_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("%0d mismatches", fail_count);
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
